FILE: design/fcgi_pkg.sv
package fcgi_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_PADDING = 2'd2
    } phase_t;

    localparam logic [1:0] CLS_HEADER  = 2'd0;
    localparam logic [1:0] CLS_CONTENT = 2'd1;
    localparam logic [1:0] CLS_PADDING = 2'd2;

    localparam logic [2:0] HDR_VERSION  = 3'd0;
    localparam logic [2:0] HDR_TYPE     = 3'd1;
    localparam logic [2:0] HDR_ID_HI    = 3'd2;
    localparam logic [2:0] HDR_ID_LO    = 3'd3;
    localparam logic [2:0] HDR_CLEN_HI  = 3'd4;
    localparam logic [2:0] HDR_CLEN_LO  = 3'd5;
    localparam logic [2:0] HDR_PADLEN   = 3'd6;
    localparam logic [2:0] HDR_RESERVED = 3'd7;

    typedef struct packed {
        logic [1:0]  byte_class;
        logic [7:0]  data_byte;
        logic [7:0]  record_version;
        logic [7:0]  record_type;
        logic [15:0] record_id;
        logic [15:0] content_length;
        logic [7:0]  padding_length;
        logic        record_end;
    } result_t;

endpackage

FILE: design/fastcgi_record_deframer.sv
// FastCGI record deframer: takes one received byte per request on the input
// channel and gives one classified result per byte on the output channel. The
// eight header bytes are captured into version, type, record id, content
// length and padding length; content bytes and then padding bytes follow, and
// record_end marks the byte that completes each record, including the last
// header byte of a record that has neither content nor padding. The parse logic
// sits between the state registers and a single output register, so a byte can
// be accepted every cycle as long as the output side keeps taking results, and a
// valid result appears in the cycle after the byte is accepted.
module fastcgi_record_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  byte_class,
    output logic [7:0]  data_byte,
    output logic [7:0]  record_version,
    output logic [7:0]  record_type,
    output logic [15:0] record_id,
    output logic [15:0] content_length,
    output logic [7:0]  padding_length,
    output logic        record_end
);

    logic              accept;
    logic              can_load;
    fcgi_pkg::result_t result;
    fcgi_pkg::result_t held;

    assign in_ready = can_load;
    assign accept   = in_valid && can_load;

    fcgi_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .rx_byte (rx_byte),
        .result  (result)
    );

    fcgi_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .held      (held)
    );

    assign byte_class     = held.byte_class;
    assign data_byte      = held.data_byte;
    assign record_version = held.record_version;
    assign record_type    = held.record_type;
    assign record_id      = held.record_id;
    assign content_length = held.content_length;
    assign padding_length = held.padding_length;
    assign record_end     = held.record_end;

endmodule

FILE: design/fcgi_parse.sv
module fcgi_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [7:0]           rx_byte,
    output fcgi_pkg::result_t    result
);

    fcgi_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] record_id_reg, record_id_next;
    logic [15:0] content_length_reg, content_length_next;
    logic [7:0]  padding_length_reg, padding_length_next;
    logic [15:0] content_rem_reg, content_rem_next;
    logic [7:0]  padding_rem_reg, padding_rem_next;
    logic [1:0]  byte_class;
    logic        record_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= fcgi_pkg::PH_HEADER;
            hdr_idx_reg        <= 3'd0;
            version_reg        <= 8'd0;
            type_reg           <= 8'd0;
            record_id_reg      <= 16'd0;
            content_length_reg <= 16'd0;
            padding_length_reg <= 8'd0;
            content_rem_reg    <= 16'd0;
            padding_rem_reg    <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            hdr_idx_reg        <= hdr_idx_next;
            version_reg        <= version_next;
            type_reg           <= type_next;
            record_id_reg      <= record_id_next;
            content_length_reg <= content_length_next;
            padding_length_reg <= padding_length_next;
            content_rem_reg    <= content_rem_next;
            padding_rem_reg    <= padding_rem_next;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        hdr_idx_next        = hdr_idx_reg;
        version_next        = version_reg;
        type_next           = type_reg;
        record_id_next      = record_id_reg;
        content_length_next = content_length_reg;
        padding_length_next = padding_length_reg;
        content_rem_next    = content_rem_reg;
        padding_rem_next    = padding_rem_reg;
        byte_class          = fcgi_pkg::CLS_HEADER;
        record_end          = 1'b0;

        case (phase_reg)
            fcgi_pkg::PH_CONTENT:
            begin
                byte_class = fcgi_pkg::CLS_CONTENT;
                if (content_rem_reg <= 16'd1)
                begin
                    content_rem_next = 16'd0;
                    if (padding_rem_reg != 8'd0)
                    begin
                        phase_next = fcgi_pkg::PH_PADDING;
                    end
                    else
                    begin
                        phase_next = fcgi_pkg::PH_HEADER;
                        record_end = 1'b1;
                    end
                end
                else
                begin
                    content_rem_next = content_rem_reg - 16'd1;
                end
            end
            fcgi_pkg::PH_PADDING:
            begin
                byte_class = fcgi_pkg::CLS_PADDING;
                if (padding_rem_reg <= 8'd1)
                begin
                    padding_rem_next = 8'd0;
                    phase_next       = fcgi_pkg::PH_HEADER;
                    record_end       = 1'b1;
                end
                else
                begin
                    padding_rem_next = padding_rem_reg - 8'd1;
                end
            end
            default:
            begin
                // The unused phase code behaves as the header phase.
                phase_next = fcgi_pkg::PH_HEADER;
                case (hdr_idx_reg)
                    fcgi_pkg::HDR_VERSION: version_next = rx_byte;
                    fcgi_pkg::HDR_TYPE:    type_next = rx_byte;
                    fcgi_pkg::HDR_ID_HI:   record_id_next[15:8] = rx_byte;
                    fcgi_pkg::HDR_ID_LO:   record_id_next[7:0] = rx_byte;
                    fcgi_pkg::HDR_CLEN_HI: content_length_next[15:8] = rx_byte;
                    fcgi_pkg::HDR_CLEN_LO: content_length_next[7:0] = rx_byte;
                    fcgi_pkg::HDR_PADLEN:  padding_length_next = rx_byte;
                    default:               ;
                endcase
                if (hdr_idx_reg == fcgi_pkg::HDR_RESERVED)
                begin
                    hdr_idx_next     = 3'd0;
                    content_rem_next = content_length_reg;
                    padding_rem_next = padding_length_reg;
                    if (content_length_reg != 16'd0)
                    begin
                        phase_next = fcgi_pkg::PH_CONTENT;
                    end
                    else if (padding_length_reg != 8'd0)
                    begin
                        phase_next = fcgi_pkg::PH_PADDING;
                    end
                    else
                    begin
                        record_end = 1'b1;
                    end
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                end
            end
        endcase

        result.byte_class     = byte_class;
        result.data_byte      = rx_byte;
        result.record_version = version_next;
        result.record_type    = type_next;
        result.record_id      = record_id_next;
        result.content_length = content_length_next;
        result.padding_length = padding_length_next;
        result.record_end     = record_end;
    end

endmodule

FILE: design/fcgi_out_stage.sv
module fcgi_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  fcgi_pkg::result_t    result,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 can_load,
    output fcgi_pkg::result_t    held
);

    logic              valid_reg, valid_next;
    fcgi_pkg::result_t held_reg;

    // A new result may enter whenever the slot is empty or is emptied this cycle.
    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign held      = held_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= result;
        end
    end

endmodule
